// ----- rtl/core/petc_pkg.sv -----
// Package for the packet epoch traffic counter: payload structs, command
// type, protocol codes and default sizes. No dependencies.
`default_nettype none

package petc_pkg;

  // Field widths fixed by the interface
  localparam int TS_W   = 52;
  localparam int LEN_W  = 32;
  localparam int WIRE_W = 16;
  localparam int BYTE_W = 48;
  localparam int TOT_W  = 32;

  // Parameter defaults
  localparam int MAX_RECORDS_DEF = 64;
  localparam int COUNT_WIDTH_DEF = 32;

  // Command queue between front and back
  localparam int CMD_DEPTH = 2;
  localparam int CMD_PW    = $clog2(CMD_DEPTH);
  localparam int CMD_CW    = $clog2(CMD_DEPTH + 1);

  localparam logic [LEN_W-1:0] EPOCH_LEN_RST    = 32'd1000000;
  localparam logic [3:0]       MIN_HEADER_WORDS = 4'd5;

  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;
  localparam logic [7:0] PROTO_ICMP = 8'd1;

  // Protocol class codes
  localparam logic [1:0] CLS_TCP   = 2'd0;
  localparam logic [1:0] CLS_UDP   = 2'd1;
  localparam logic [1:0] CLS_ICMP  = 2'd2;
  localparam logic [1:0] CLS_OTHER = 2'd3;

  // Input item kinds
  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_END    = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [TS_W-1:0]   timestamp_us;
    logic [3:0]        header_words;
    logic [7:0]        protocol;
    logic [WIRE_W-1:0] wire_length;
  } in_item_t;

  typedef struct packed {
    logic [TS_W-1:0]   epoch_start_us;
    logic [TOT_W-1:0]  packet_total;
    logic [BYTE_W-1:0] byte_total;
    logic [TOT_W-1:0]  tcp_total;
    logic [TOT_W-1:0]  udp_total;
    logic [TOT_W-1:0]  icmp_total;
    logic [TOT_W-1:0]  other_total;
    logic              epochs_skipped;
    logic              last_record;
  } out_rec_t;

  // Classified command handed from front to back
  typedef struct packed {
    logic              is_end;
    logic [TS_W-1:0]   timestamp_us;
    logic [1:0]        cls;
    logic [WIRE_W-1:0] wire_length;
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/petc_front.sv -----
// Front end: accepts input transactions, drops short-header packets and
// classifies the protocol into a command. Depends on petc_pkg.
`default_nettype none

module petc_front import petc_pkg::*; (
  input  wire in_item_t in_data,
  input  wire logic     push,
  output logic          full,
  input  wire logic     q_full,
  output logic          q_push,
  output cmd_t          q_cmd
);

  logic keep;

  // Pass queue backpressure straight to the input side
  assign full = q_full;

  // Keep end items and packets with a full-size header
  assign keep   = (in_data.kind == KIND_END) || (in_data.header_words >= MIN_HEADER_WORDS);
  assign q_push = push && !q_full && keep;

  // Classify the protocol
  always_comb begin
    q_cmd.is_end       = (in_data.kind == KIND_END);
    q_cmd.timestamp_us = in_data.timestamp_us;
    q_cmd.wire_length  = in_data.wire_length;
    if (in_data.protocol == PROTO_TCP) begin
      q_cmd.cls = CLS_TCP;
    end else if (in_data.protocol == PROTO_UDP) begin
      q_cmd.cls = CLS_UDP;
    end else if (in_data.protocol == PROTO_ICMP) begin
      q_cmd.cls = CLS_ICMP;
    end else begin
      q_cmd.cls = CLS_OTHER;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/petc_cmd_fifo.sv -----
// Short command queue between front and back end so either side can stall.
// Depends on petc_pkg.
`default_nettype none

module petc_cmd_fifo import petc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t din,
  output logic      full,
  input  wire logic pop,
  output cmd_t      dout,
  output logic      empty
);

  cmd_t              mem_r [CMD_DEPTH];
  logic [CMD_PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMD_PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMD_CW-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = (cnt_r == CMD_CW'(CMD_DEPTH));
  assign empty   = (cnt_r == '0);
  assign dout    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == CMD_PW'(CMD_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == CMD_PW'(CMD_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/petc_rem.sv -----
// Bit-serial restoring remainder unit: timestamp distance modulo the epoch
// length, one dividend bit per cycle. Depends on petc_pkg.
`default_nettype none

module petc_rem import petc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [TS_W-1:0]  dividend,
  input  wire logic [LEN_W-1:0] divisor,
  output logic                  done,
  output logic [LEN_W-1:0]      rem
);

  localparam int CNT_W = $clog2(TS_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [TS_W-1:0]  dvd_r, dvd_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [LEN_W-1:0] div_r, div_nxt;
  logic [LEN_W:0]   trial;
  logic [LEN_W:0]   diff;
  logic             ge;

  assign done = done_r;
  assign rem  = rem_r;

  // Shift in the next dividend bit and subtract when it fits
  assign trial = {rem_r, dvd_r[TS_W-1]};
  assign diff  = trial - {1'b0, div_r};
  assign ge    = (trial >= {1'b0, div_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
      dvd_nxt = {dvd_r[TS_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(TS_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/core/petc_back.sv -----
// Back end: epoch state, counters, epoch closing sequencer and the result
// register. Depends on petc_pkg and petc_rem.
`default_nettype none

module petc_back import petc_pkg::*; #(
  parameter int MAX_RECORDS = MAX_RECORDS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [LEN_W-1:0] cfg_wdata,
  input  wire logic             q_empty,
  input  wire cmd_t             q_cmd,
  output logic                  q_pop,
  output logic                  empty,
  input  wire logic             pop,
  output out_rec_t              out_data
);

  localparam int CNT_W = (COUNT_WIDTH > TOT_W) ? TOT_W : COUNT_WIDTH;
  localparam int RC_W  = $clog2(MAX_RECORDS + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_MORE   = 3'd2;
  localparam logic [2:0] ST_REM    = 3'd3;
  localparam logic [2:0] ST_COUNT  = 3'd4;
  localparam logic [2:0] ST_ENDREC = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic              started_r, started_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  cmd_t              cur_r, cur_nxt;
  logic [TS_W-1:0]   es_r, es_nxt;
  logic [TS_W:0]     es_pl_r, es_pl_nxt;
  logic [RC_W-1:0]   rec_r, rec_nxt;
  logic [CNT_W-1:0]  pkt_r, pkt_nxt;
  logic [BYTE_W-1:0] byt_r, byt_nxt;
  logic [CNT_W-1:0]  tcp_r, tcp_nxt;
  logic [CNT_W-1:0]  udp_r, udp_nxt;
  logic [CNT_W-1:0]  icmp_r, icmp_nxt;
  logic [CNT_W-1:0]  oth_r, oth_nxt;
  logic              ov_r, ov_nxt;
  out_rec_t          out_r, out_nxt;

  logic              can_load;
  logic [TS_W:0]     es_plus_len;
  logic [TS_W+1:0]   es_plus_2len;
  logic              close;
  logic              more;
  logic              rec_limit;
  logic [BYTE_W:0]   byte_sum;
  logic              rem_start;
  logic              rem_done;
  logic [LEN_W-1:0]  rem_val;
  logic [TS_W-1:0]   rem_dividend;

  assign empty    = !ov_r;
  assign out_data = out_r;
  assign can_load = !ov_r || pop;

  // Epoch boundary compares
  assign es_plus_len  = {1'b0, es_r} + (TS_W+1)'(len_r);
  assign close        = ((TS_W+1)'(cur_r.timestamp_us) > es_plus_len);
  assign es_plus_2len = {1'b0, es_pl_r} + (TS_W+2)'(len_r);
  assign more         = ((TS_W+2)'(cur_r.timestamp_us) > es_plus_2len);
  assign rec_limit    = (rec_r == RC_W'(MAX_RECORDS - 1));
  assign byte_sum     = {1'b0, byt_r} + (BYTE_W+1)'(cur_r.wire_length);
  assign rem_dividend = cur_r.timestamp_us - es_pl_r[TS_W-1:0];

  petc_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (rem_dividend),
    .divisor  (len_r),
    .done     (rem_done),
    .rem      (rem_val)
  );

  always_comb begin
    state_nxt   = state_r;
    started_nxt = started_r;
    len_nxt     = len_r;
    cur_nxt     = cur_r;
    es_nxt      = es_r;
    es_pl_nxt   = es_pl_r;
    rec_nxt     = rec_r;
    pkt_nxt     = pkt_r;
    byt_nxt     = byt_r;
    tcp_nxt     = tcp_r;
    udp_nxt     = udp_r;
    icmp_nxt    = icmp_r;
    oth_nxt     = oth_r;
    ov_nxt      = ov_r && !pop;
    out_nxt     = out_r;
    q_pop       = 1'b0;
    rem_start   = 1'b0;

    // Latch the epoch length; zero acts as one
    if (cfg_we) begin
      len_nxt = (cfg_wdata == '0) ? LEN_W'(1) : cfg_wdata;
    end

    // Current epoch as a record
    out_nxt.epoch_start_us = es_r;
    out_nxt.packet_total   = TOT_W'(pkt_r);
    out_nxt.byte_total     = byt_r;
    out_nxt.tcp_total      = TOT_W'(tcp_r);
    out_nxt.udp_total      = TOT_W'(udp_r);
    out_nxt.icmp_total     = TOT_W'(icmp_r);
    out_nxt.other_total    = TOT_W'(oth_r);
    out_nxt.epochs_skipped = 1'b0;
    out_nxt.last_record    = 1'b1;
    if (!(can_load && (state_r == ST_MORE || state_r == ST_ENDREC))) begin
      out_nxt = out_r;
    end

    unique case (state_r)
      // Take the next command
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cur_nxt = q_cmd;
          rec_nxt = '0;
          if (q_cmd.is_end) begin
            if (started_r) begin
              state_nxt = ST_ENDREC;
            end
          end else begin
            if (!started_r) begin
              started_nxt = 1'b1;
              es_nxt      = q_cmd.timestamp_us;
            end
            state_nxt = ST_CHECK;
          end
        end
      end
      // Does the packet lie past the open epoch
      ST_CHECK: begin
        es_pl_nxt = es_plus_len;
        state_nxt = close ? ST_MORE : ST_COUNT;
      end
      // Emit one closed epoch and advance
      ST_MORE: begin
        if (can_load) begin
          ov_nxt                 = 1'b1;
          out_nxt.epochs_skipped = more && rec_limit;
          out_nxt.last_record    = !more || rec_limit;
          es_nxt                 = es_pl_r[TS_W-1:0];
          rec_nxt                = rec_r + 1'b1;
          pkt_nxt                = '0;
          byt_nxt                = '0;
          tcp_nxt                = '0;
          udp_nxt                = '0;
          icmp_nxt               = '0;
          oth_nxt                = '0;
          if (!more) begin
            state_nxt = ST_COUNT;
          end else if (rec_limit) begin
            rem_start = 1'b1;
            state_nxt = ST_REM;
          end else begin
            state_nxt = ST_CHECK;
          end
        end
      end
      // Jump over the silent epochs
      ST_REM: begin
        if (rem_done) begin
          es_nxt    = (rem_val == '0) ? cur_r.timestamp_us - TS_W'(len_r)
                                      : cur_r.timestamp_us - TS_W'(rem_val);
          state_nxt = ST_COUNT;
        end
      end
      // Count the packet in the open epoch
      ST_COUNT: begin
        pkt_nxt = (&pkt_r) ? pkt_r : pkt_r + 1'b1;
        byt_nxt = byte_sum[BYTE_W] ? '1 : byte_sum[BYTE_W-1:0];
        unique case (cur_r.cls)
          CLS_TCP:  tcp_nxt  = (&tcp_r)  ? tcp_r  : tcp_r + 1'b1;
          CLS_UDP:  udp_nxt  = (&udp_r)  ? udp_r  : udp_r + 1'b1;
          CLS_ICMP: icmp_nxt = (&icmp_r) ? icmp_r : icmp_r + 1'b1;
          default:  oth_nxt  = (&oth_r)  ? oth_r  : oth_r + 1'b1;
        endcase
        state_nxt = ST_IDLE;
      end
      // Flush the open epoch on an end item
      ST_ENDREC: begin
        if (can_load) begin
          ov_nxt    = 1'b1;
          es_nxt    = es_plus_len[TS_W-1:0];
          pkt_nxt   = '0;
          byt_nxt   = '0;
          tcp_nxt   = '0;
          udp_nxt   = '0;
          icmp_nxt  = '0;
          oth_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      started_r <= 1'b0;
      len_r     <= EPOCH_LEN_RST;
      es_r      <= '0;
      pkt_r     <= '0;
      byt_r     <= '0;
      tcp_r     <= '0;
      udp_r     <= '0;
      icmp_r    <= '0;
      oth_r     <= '0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      started_r <= started_nxt;
      len_r     <= len_nxt;
      es_r      <= es_nxt;
      pkt_r     <= pkt_nxt;
      byt_r     <= byt_nxt;
      tcp_r     <= tcp_nxt;
      udp_r     <= udp_nxt;
      icmp_r    <= icmp_nxt;
      oth_r     <= oth_nxt;
      ov_r      <= ov_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    es_pl_r <= es_pl_nxt;
    rec_r   <= rec_nxt;
    out_r   <= out_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/core/packet_epoch_traffic_counter.sv -----
// Top level of the packet epoch traffic counter: front end, command queue
// and back end. Depends on petc_pkg, petc_front, petc_cmd_fifo, petc_back.
//
// Usage:
//   Input queue: drive in_data and push; a transaction is taken at a clock
//   edge with push high and full low. Packets with a header under five words
//   are taken and dropped. End items flush the open epoch.
//   Result queue: while empty is low the oldest record is on out_data; pop
//   with empty low takes it. Each record holds the counts of one closed epoch.
//   Configuration: cfg_we with cfg_wdata sets the epoch length in
//   microseconds (reset 1000000, zero acts as one); write only while idle.
//   Sequence: a packet that closes no epoch is taken from the command queue,
//   passes the boundary compare and is counted. Each further record takes a
//   boundary compare and an emit in the epoch sequencer. When the record
//   limit is hit, the jump over the remaining epochs runs the bit-serial
//   remainder unit.
//   Reset: state, counters and queues clear; the epoch length returns to
//   its default. A stalled result side holds the back end once the result
//   register is full; the two-entry command queue takes input until it fills.
`default_nettype none

module packet_epoch_traffic_counter import petc_pkg::*; #(
  parameter int MAX_RECORDS = MAX_RECORDS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire in_item_t         in_data,
  input  wire logic             push,
  output logic                  full,
  output out_rec_t              out_data,
  output logic                  empty,
  input  wire logic             pop,
  input  wire logic             cfg_we,
  input  wire logic [LEN_W-1:0] cfg_wdata
);

  logic q_push, q_full, q_pop, q_empty;
  cmd_t q_din, q_dout;

  petc_front u_front (
    .in_data (in_data),
    .push    (push),
    .full    (full),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (q_din)
  );

  petc_cmd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  petc_back #(
    .MAX_RECORDS (MAX_RECORDS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_empty   (q_empty),
    .q_cmd     (q_dout),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- rtl/core/petc_checker.sv -----
// Port-level checker for the packet epoch traffic counter and its bind.
// Depends on petc_pkg.
`default_nettype none

module petc_checker import petc_pkg::*; (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     full,
  input wire out_rec_t out_data,
  input wire logic     empty,
  input wire logic     pop
);

  // Queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> (empty && !full))
    else $error("queues not empty after reset");

  // A waiting record holds until popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("waiting record changed");

  // Skip flag only on the last record of a transaction
  a_skip_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.epochs_skipped) |-> out_data.last_record)
    else $error("skip flag without last record");

  // Class counts never exceed the packet count
  a_class_le: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_data.tcp_total <= out_data.packet_total &&
                out_data.udp_total <= out_data.packet_total &&
                out_data.icmp_total <= out_data.packet_total &&
                out_data.other_total <= out_data.packet_total))
    else $error("class count above packet count");

endmodule

bind packet_epoch_traffic_counter petc_checker u_petc_checker (.*);

`default_nettype wire
